// ===== rtl/skos_pkg.sv =====
// Shared types and constants for the sorted-key outward search block.
// Holds the transaction structs, item kind codes and the microcode word format.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skos_pkg;

  // Default sizing
  localparam int DEPTH_DEF    = 1024;
  localparam int KEY_BITS_DEF = 32;

  // Fixed field widths
  localparam int KIND_W = 3;
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int ID_W   = 32;
  localparam int CNT_W  = 11;
  // Distances are at most 33 bits signed and the bound 32 bits signed
  localparam int CMP_W  = 33;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NEAR  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LEFT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RIGHT = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic [ID_W-1:0]         entry_tag;
  } in_item_t;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] point_id_out;
    logic            from_left;
  } out_item_t;

  // Microcode step addresses
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] S_IDLE   = 5'd0;
  localparam logic [PC_W-1:0] S_LOAD   = 5'd1;
  localparam logic [PC_W-1:0] S_INIT   = 5'd2;
  localparam logic [PC_W-1:0] S_PROBE  = 5'd3;
  localparam logic [PC_W-1:0] S_BISECT = 5'd4;
  localparam logic [PC_W-1:0] S_SETCUR = 5'd5;
  localparam logic [PC_W-1:0] S_NRD_L  = 5'd6;
  localparam logic [PC_W-1:0] S_NRD_R  = 5'd7;
  localparam logic [PC_W-1:0] S_NCAP_R = 5'd8;
  localparam logic [PC_W-1:0] S_NEMIT  = 5'd9;
  localparam logic [PC_W-1:0] S_LRD    = 5'd10;
  localparam logic [PC_W-1:0] S_LCAP   = 5'd11;
  localparam logic [PC_W-1:0] S_LEMIT  = 5'd12;
  localparam logic [PC_W-1:0] S_RRD    = 5'd13;
  localparam logic [PC_W-1:0] S_RCAP   = 5'd14;
  localparam logic [PC_W-1:0] S_REMIT  = 5'd15;
  localparam logic [PC_W-1:0] S_NOP    = 5'd16;

  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_WRITE      = 4'd1,
    OP_INIT       = 4'd2,
    OP_BISECT     = 4'd3,
    OP_SETCUR     = 4'd4,
    OP_CAPL       = 4'd5,
    OP_CAPR       = 4'd6,
    OP_EMIT_NEAR  = 4'd7,
    OP_EMIT_LEFT  = 4'd8,
    OP_EMIT_RIGHT = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    AS_MID   = 2'd0,
    AS_LEFT  = 2'd1,
    AS_RIGHT = 2'd2
  } addr_sel_e;

  typedef enum logic [1:0] {
    J_NEXT    = 2'd0,
    J_IDLE    = 2'd1,
    J_ALWAYS  = 2'd2,
    J_IF_DONE = 2'd3
  } jump_e;

  // One control word of the program
  typedef struct packed {
    op_e             op;
    addr_sel_e       rd_sel;
    logic            rd_en;
    logic            emit;
    jump_e           jmp;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Status fed back from the datapath to the sequencer
  typedef struct packed {
    logic search_done;
    logic hold;
  } seq_cond_t;

endpackage

`default_nettype wire

// ===== rtl/skos_seq.sv =====
// Microcode sequencer: step counter, program table and jump logic.
// Depends on skos_pkg for the control word and step addresses.
`timescale 1ns / 1ps
`default_nettype none

module skos_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [skos_pkg::KIND_W-1:0]   kind_i,
  input  wire skos_pkg::seq_cond_t           cond_i,
  output skos_pkg::ctrl_t                    ctrl_o,
  output logic                               idle_o
);
  import skos_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;

  // Build one control word
  function automatic ctrl_t mk(op_e op, addr_sel_e sel, logic rd, logic em, jump_e jmp,
                               logic [PC_W-1:0] tgt);
    ctrl_t w;
    w.op     = op;
    w.rd_sel = sel;
    w.rd_en  = rd;
    w.emit   = em;
    w.jmp    = jmp;
    w.target = tgt;
    return w;
  endfunction

  // Program table
  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t w;
    w = mk(OP_NONE, AS_MID, 1'b0, 1'b0, J_IDLE, S_IDLE);
    case (pc)
      S_LOAD:   w = mk(OP_WRITE,      AS_MID,   1'b0, 1'b1, J_IDLE,    S_IDLE);
      S_INIT:   w = mk(OP_INIT,       AS_MID,   1'b0, 1'b0, J_NEXT,    S_IDLE);
      S_PROBE:  w = mk(OP_NONE,       AS_MID,   1'b1, 1'b0, J_IF_DONE, S_SETCUR);
      S_BISECT: w = mk(OP_BISECT,     AS_MID,   1'b0, 1'b0, J_ALWAYS,  S_PROBE);
      S_SETCUR: w = mk(OP_SETCUR,     AS_MID,   1'b0, 1'b1, J_IDLE,    S_IDLE);
      S_NRD_L:  w = mk(OP_NONE,       AS_LEFT,  1'b1, 1'b0, J_NEXT,    S_IDLE);
      S_NRD_R:  w = mk(OP_CAPL,       AS_RIGHT, 1'b1, 1'b0, J_NEXT,    S_IDLE);
      S_NCAP_R: w = mk(OP_CAPR,       AS_MID,   1'b0, 1'b0, J_NEXT,    S_IDLE);
      S_NEMIT:  w = mk(OP_EMIT_NEAR,  AS_MID,   1'b0, 1'b1, J_IDLE,    S_IDLE);
      S_LRD:    w = mk(OP_NONE,       AS_LEFT,  1'b1, 1'b0, J_NEXT,    S_IDLE);
      S_LCAP:   w = mk(OP_CAPL,       AS_MID,   1'b0, 1'b0, J_NEXT,    S_IDLE);
      S_LEMIT:  w = mk(OP_EMIT_LEFT,  AS_MID,   1'b0, 1'b1, J_IDLE,    S_IDLE);
      S_RRD:    w = mk(OP_NONE,       AS_RIGHT, 1'b1, 1'b0, J_NEXT,    S_IDLE);
      S_RCAP:   w = mk(OP_CAPR,       AS_MID,   1'b0, 1'b0, J_NEXT,    S_IDLE);
      S_REMIT:  w = mk(OP_EMIT_RIGHT, AS_MID,   1'b0, 1'b1, J_IDLE,    S_IDLE);
      S_NOP:    w = mk(OP_NONE,       AS_MID,   1'b0, 1'b1, J_IDLE,    S_IDLE);
      default:  w = mk(OP_NONE,       AS_MID,   1'b0, 1'b0, J_IDLE,    S_IDLE);
    endcase
    return w;
  endfunction

  // Entry step for each item kind
  function automatic logic [PC_W-1:0] dispatch(logic [KIND_W-1:0] kind);
    logic [PC_W-1:0] p;
    case (kind)
      KIND_LOAD:  p = S_LOAD;
      KIND_START: p = S_INIT;
      KIND_NEAR:  p = S_NRD_L;
      KIND_LEFT:  p = S_LRD;
      KIND_RIGHT: p = S_RRD;
      default:    p = S_NOP;
    endcase
    return p;
  endfunction

  assign ctrl_o = ucode(pc_q);
  assign idle_o = (pc_q == S_IDLE);

  // Next step: dispatch from idle, hold while the result slot is blocked, else jump
  always_comb begin
    pc_d = pc_q;
    if (pc_q == S_IDLE) begin
      if (start_i) begin
        pc_d = dispatch(kind_i);
      end
    end else if (!cond_i.hold) begin
      unique case (ctrl_o.jmp)
        J_NEXT:    pc_d = pc_q + 1'b1;
        J_IDLE:    pc_d = S_IDLE;
        J_ALWAYS:  pc_d = ctrl_o.target;
        J_IF_DONE: pc_d = cond_i.search_done ? ctrl_o.target : pc_q + 1'b1;
        default:   pc_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_key_outward_search.sv =====
// Top level of the sorted-key outward search: table memory, cursors and result register.
// Depends on skos_pkg and skos_seq.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one item per transaction:
//   load, start query, find nearest, find left or find right. Every item gives exactly one
//   result transaction on the output channel (out_valid_o / out_stall_i / out_data_o).
//   The configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the entry
//   count; write it only while no item is in progress.
// Steps: load and unknown kinds go straight to their final step; find left / find right read
//   their cursor entry and capture it; find nearest reads and captures both cursor entries;
//   start query sets the bounds, then makes at most clog2(DEPTH) + 1 bisection steps and
//   sets the cursors. The table memory has a single read port: every probe and every cursor
//   look-up is one registered read.
// One item is worked on at a time; the next is taken only once the sequencer is back in idle,
// after the previous one has placed its result in the output register, even while that result
// waits. Reset clears the cursors, the query key, the entry count and the result valid flag;
// the table contents are undefined until loaded. A stalled receiver holds the result and,
// once the next item reaches its final step, holds that item too.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_outward_search #(
  parameter int DEPTH    = skos_pkg::DEPTH_DEF,
  parameter int KEY_BITS = skos_pkg::KEY_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire skos_pkg::in_item_t           in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output skos_pkg::out_item_t               out_data_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [skos_pkg::CNT_W-1:0]   cfg_data_i
);
  import skos_pkg::*;

  localparam int KW  = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int DW  = KW + 1;
  localparam int PW  = $clog2(DEPTH);
  localparam int NW  = PW + 1;
  localparam int MW  = KW + ID_W;
  localparam int CW  = (CNT_W > NW) ? CNT_W : NW;
  localparam int IXW = (IDX_W > NW) ? IDX_W : NW;

  ctrl_t     ctrl;
  seq_cond_t cond;
  logic      seq_idle;
  logic      start;
  logic      emit_go;

  in_item_t            item_q;
  logic [CNT_W-1:0]    entry_count_q;
  logic signed [KW-1:0] query_key_q;
  logic [NW-1:0]       lo_q, hi_q;
  logic [PW-1:0]       left_pos_q, right_pos_q;
  logic                left_valid_q, right_valid_q;
  logic [MW-1:0]       entry_mem_q [DEPTH];
  logic [MW-1:0]       rd_q;
  logic signed [DW-1:0] dl_q, dr_q;
  logic [ID_W-1:0]     id_l_q, id_r_q;
  logic                out_valid_q;
  out_item_t           out_q;

  // Sequencer
  assign start = in_valid_i && seq_idle;

  skos_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (in_data_i.kind),
    .cond_i  (cond),
    .ctrl_o  (ctrl),
    .idle_o  (seq_idle)
  );

  assign in_stall_o  = !seq_idle;
  assign cfg_ready_o = 1'b1;

  // Final steps proceed only when the result register can take the transaction
  assign emit_go          = ctrl.emit && (!out_valid_q || !out_stall_i);
  assign cond.hold        = ctrl.emit && !emit_go;
  assign cond.search_done = !(lo_q < hi_q);

  // Entries in use, clamped to the table depth
  logic [CW-1:0] cnt_ext, depth_ext;
  logic [NW-1:0] used_n;
  assign cnt_ext   = CW'(entry_count_q);
  assign depth_ext = CW'(DEPTH);
  assign used_n    = (cnt_ext > depth_ext) ? NW'(depth_ext) : NW'(cnt_ext);

  // Bisection midpoint
  logic [NW:0]   mid_sum;
  logic [PW-1:0] mid;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[PW:1];

  // Read address select
  logic [PW-1:0] rd_addr;
  always_comb begin
    unique case (ctrl.rd_sel)
      AS_MID:   rd_addr = mid;
      AS_LEFT:  rd_addr = left_pos_q;
      AS_RIGHT: rd_addr = right_pos_q;
      default:  rd_addr = '0;
    endcase
  end

  // Load write
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  assign wr_en   = emit_go && (ctrl.op == OP_WRITE) && (IXW'(item_q.index) < IXW'(DEPTH));
  assign wr_addr = PW'(item_q.index);

  // Table memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem_q[wr_addr] <= {item_q.entry_tag, item_q.value[KW-1:0]};
    end
    if (ctrl.rd_en) begin
      rd_q <= entry_mem_q[rd_addr];
    end
  end

  logic signed [KW-1:0] rd_key;
  logic [ID_W-1:0]      rd_id;
  assign rd_key = $signed(rd_q[KW-1:0]);
  assign rd_id  = rd_q[MW-1:KW];

  // Distances from the query key
  logic signed [DW-1:0] dl_calc, dr_calc;
  assign dl_calc = DW'(query_key_q) - DW'(rd_key);
  assign dr_calc = DW'(rd_key) - DW'(query_key_q);

  // Capture cursor entries
  always_ff @(posedge clk_i) begin
    if (ctrl.op == OP_CAPL) begin
      dl_q   <= dl_calc;
      id_l_q <= rd_id;
    end
    if (ctrl.op == OP_CAPR) begin
      dr_q   <= dr_calc;
      id_r_q <= rd_id;
    end
  end

  // Bound checks and nearest choice
  logic signed [CMP_W-1:0] bound_ext, dl_ext, dr_ext;
  logic left_ok, right_ok, near_left, near_ok;
  assign bound_ext = CMP_W'($signed(item_q.value));
  assign dl_ext    = CMP_W'(dl_q);
  assign dr_ext    = CMP_W'(dr_q);
  assign left_ok   = left_valid_q && !(dl_ext > bound_ext);
  assign right_ok  = right_valid_q && !(dr_ext > bound_ext);
  assign near_left = left_valid_q && (!right_valid_q || (dl_q <= dr_q));
  assign near_ok   = near_left ? left_ok : right_ok;

  // Result of the current step
  logic            res_found, res_left;
  logic [ID_W-1:0] res_id;
  always_comb begin
    res_found = 1'b0;
    res_left  = 1'b0;
    res_id    = id_r_q;
    unique case (ctrl.op)
      OP_EMIT_NEAR: begin
        res_found = near_ok;
        res_left  = near_left;
        res_id    = near_left ? id_l_q : id_r_q;
      end
      OP_EMIT_LEFT: begin
        res_found = left_ok;
        res_left  = 1'b1;
        res_id    = id_l_q;
      end
      OP_EMIT_RIGHT: begin
        res_found = right_ok;
      end
      default: begin
        res_found = 1'b0;
      end
    endcase
  end

  logic take_left, take_right;
  assign take_left  = emit_go && res_found && res_left;
  assign take_right = emit_go && res_found && !res_left;

  // Cursor set-up and stepping helpers
  logic [NW-1:0] lo_m1, right_next;
  assign lo_m1      = lo_q - NW'(1);
  assign right_next = {1'b0, right_pos_q} + NW'(1);

  // Hold the latched item
  always_ff @(posedge clk_i) begin
    if (start) begin
      item_q <= in_data_i;
    end
  end

  // Control state: count, query key, search bounds, cursors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      query_key_q   <= '0;
      lo_q          <= '0;
      hi_q          <= '0;
      left_pos_q    <= '0;
      left_valid_q  <= 1'b0;
      right_pos_q   <= '0;
      right_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        entry_count_q <= cfg_data_i;
      end
      if (ctrl.op == OP_INIT) begin
        query_key_q <= $signed(item_q.value[KW-1:0]);
        lo_q        <= '0;
        hi_q        <= used_n;
      end
      if (ctrl.op == OP_BISECT) begin
        if (rd_key < query_key_q) begin
          lo_q <= {1'b0, mid} + NW'(1);
        end else begin
          hi_q <= {1'b0, mid};
        end
      end
      if (emit_go && (ctrl.op == OP_SETCUR)) begin
        left_valid_q  <= (lo_q != '0);
        left_pos_q    <= (lo_q != '0) ? lo_m1[PW-1:0] : '0;
        right_valid_q <= (lo_q < used_n);
        right_pos_q   <= (lo_q < used_n) ? lo_q[PW-1:0] : '0;
      end
      // Step the emitting cursor outward
      if (take_left) begin
        if (left_pos_q == '0) begin
          left_valid_q <= 1'b0;
        end else begin
          left_pos_q <= left_pos_q - 1'b1;
        end
      end
      if (take_right) begin
        if (right_next >= used_n) begin
          right_valid_q <= 1'b0;
        end else begin
          right_pos_q <= right_next[PW-1:0];
        end
      end
    end
  end

  // Result register: refill on emit, drop on transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_q.found        <= res_found;
      out_q.point_id_out <= res_found ? res_id : '0;
      out_q.from_left    <= res_found && res_left;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Bisection bounds stay ordered
  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= hi_q)
    else $error("search bounds crossed");

  // The sequencer returns to idle only through a result write
  a_idle_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(seq_idle) |-> $past(emit_go))
    else $error("item finished without a result");

  // Loads, starts and unknown kinds never report a hit
  a_no_hit_non_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go && (ctrl.op != OP_EMIT_NEAR) && (ctrl.op != OP_EMIT_LEFT)
      && (ctrl.op != OP_EMIT_RIGHT) |=> !out_q.found)
    else $error("hit reported by a non-find item");

  // A left hit moves the left cursor one step down
  a_left_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_left && (left_pos_q != '0) |=> (left_pos_q == $past(left_pos_q) - 1'b1))
    else $error("left cursor did not step");

endmodule

`default_nettype wire
